// File: hw/rtl/ntsd_pkg.sv
// ----------------------------------------------------------------------------
// ntsd_pkg
// Shared types and constants for the nearest two seed distance block.
// ----------------------------------------------------------------------------
package ntsd_pkg;

  localparam int DEF_MAX_SEEDS = 256;
  localparam int FRAC_BITS     = 4;

  // field widths
  localparam int COORD_W = 16;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;
  localparam int THR_W   = 8;
  localparam int NEAR_W  = 12;
  localparam int GAP_W   = 17;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 1;

  // squared distance and root widths
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ1_W    = 2 * COORD_W;
  localparam int SQ_W     = SQ1_W + 1;
  localparam int RT_W     = (SQ_W + 1) / 2;
  localparam int RT_VAL_W = 2 * RT_W;
  localparam int REM_W    = RT_W + 2;
  localparam int STEP_W   = $clog2(RT_W + 1);

  localparam int NEAR_CLAMP = 255 << FRAC_BITS;

  // op codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROOT1,
    ST_ROOT2,
    ST_HOLD
  } state_t;

endpackage

// File: hw/rtl/nearest_two_seed_distance.sv
// Operation: a seed write is stored when it is accepted. A query, from accept to result,
// scans n = min(point_count, MAX_SEEDS) seeds, one seed read per cycle, drains
// the read and square registers, then runs two 17-step square roots in one unit.
// A new item is taken only in idle, once the query result is loaded into the
// result register; a result held by out_stall holds off the next result.
// Reset: point_count = 0, edge_threshold = 2, no result pending; seed memory not cleared.
// ----------------------------------------------------------------------------
// nearest_two_seed_distance
// Worley style F1 / F2 search over a table of seed points.
// ----------------------------------------------------------------------------
module nearest_two_seed_distance #(
  parameter int MAX_SEEDS = ntsd_pkg::DEF_MAX_SEEDS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_write,
  input  logic [ntsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ntsd_pkg::CFG_W-1:0]           cfg_data,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 op,
  input  logic [ntsd_pkg::INDEX_W-1:0]         seed_index,
  input  logic signed [ntsd_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [ntsd_pkg::COORD_W-1:0]  pos_y,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ntsd_pkg::NEAR_W-1:0]          nearest_distance,
  output logic [ntsd_pkg::GAP_W-1:0]           gap_distance,
  output logic                                 on_edge,
  output logic                                 too_few_seeds
);
  import ntsd_pkg::*;

  localparam int AW    = $clog2(MAX_SEEDS);
  localparam int CNT_W = $clog2(MAX_SEEDS + 1);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [COUNT_W-1:0] point_count;
  logic [THR_W-1:0]   edge_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count    <= '0;
      edge_threshold <= THR_W'(2);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POINT_COUNT:    point_count    <= cfg_data[COUNT_W-1:0];
        REG_EDGE_THRESHOLD: edge_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  state_t state, state_next;

  logic             in_accept;
  logic             out_free;
  logic             issue_done;
  logic             pipe_empty;
  logic             rd_en;
  logic             root_last;
  logic [CNT_W-1:0] addr_cnt;
  logic [CNT_W-1:0] scan_len;
  logic [CNT_W-1:0] scan_len_next;
  logic             rd_valid;
  logic             sq_valid;
  logic [STEP_W-1:0] rt_cnt;

  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign issue_done = (addr_cnt == scan_len);
  assign pipe_empty = !rd_valid && !sq_valid;
  assign root_last  = (rt_cnt == STEP_W'(RT_W - 1));

  // point_count above the table depth scans the whole table
  always_comb begin
    if (32'(point_count) > 32'(MAX_SEEDS)) scan_len_next = CNT_W'(MAX_SEEDS);
    else                                   scan_len_next = CNT_W'(point_count);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && op == OP_QUERY) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue_done && pipe_empty) state_next = ST_ROOT1;
      end
      ST_ROOT1: begin
        if (root_last) state_next = ST_ROOT2;
      end
      ST_ROOT2: begin
        if (root_last) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // only idle takes items, so seed writes never overlap a scan
  always_comb begin
    in_stall = (state != ST_IDLE);
    rd_en    = (state == ST_SCAN) && !issue_done;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // --------------------------------------------------------------------------
  // seed memory: x in the upper half, y in the lower
  // --------------------------------------------------------------------------
  logic [2*COORD_W-1:0] seed_mem [MAX_SEEDS];
  logic [2*COORD_W-1:0] rd_data;
  logic [31:0]          wr_idx;
  logic                 wr_en;

  assign wr_idx = 32'(seed_index);
  assign wr_en  = in_accept && op == OP_WRITE && wr_idx < 32'(MAX_SEEDS);

  always_ff @(posedge clk) begin
    if (wr_en) seed_mem[wr_idx[AW-1:0]] <= {pos_x, pos_y};
    if (rd_en) rd_data <= seed_mem[addr_cnt[AW-1:0]];
  end

  // --------------------------------------------------------------------------
  // scan pipeline: read -> squares -> running F1/F2
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] qx, qy;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic signed [2*DIFF_W-1:0] px, py;
  logic [SQ1_W-1:0]          sq_x, sq_y;
  logic [SQ_W-1:0]           sq_sum;
  logic [SQ_W-1:0]           best1, best2;
  logic                      have1, have2;

  assign dx = DIFF_W'(qx) - DIFF_W'($signed(rd_data[2*COORD_W-1:COORD_W]));
  assign dy = DIFF_W'(qy) - DIFF_W'($signed(rd_data[COORD_W-1:0]));
  assign px = dx * dx;
  assign py = dy * dy;
  // |d| <= 65535, so each square fits 32 bits unsigned
  assign sq_sum = SQ_W'(sq_x) + SQ_W'(sq_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_cnt <= '0;
      rd_valid <= 1'b0;
      sq_valid <= 1'b0;
      have1    <= 1'b0;
      have2    <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      sq_valid <= rd_valid;
      if (in_accept && op == OP_QUERY) begin
        addr_cnt <= '0;
        have1    <= 1'b0;
        have2    <= 1'b0;
      end else begin
        if (rd_en) addr_cnt <= addr_cnt + CNT_W'(1);
        if (sq_valid) begin
          // a tie with F1 goes to F2, so duplicate seeds give a zero gap
          if (!have1 || sq_sum < best1) begin
            if (have1) have2 <= 1'b1;
            have1 <= 1'b1;
          end else if (!have2 || sq_sum < best2) begin
            have2 <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && op == OP_QUERY) begin
      qx       <= pos_x;
      qy       <= pos_y;
      scan_len <= scan_len_next;
    end
    if (rd_valid) begin
      sq_x <= px[SQ1_W-1:0];
      sq_y <= py[SQ1_W-1:0];
    end
    if (sq_valid) begin
      if (!have1 || sq_sum < best1) begin
        best2 <= best1;
        best1 <= sq_sum;
      end else if (!have2 || sq_sum < best2) begin
        best2 <= sq_sum;
      end
    end
  end

  // --------------------------------------------------------------------------
  // shared square root, one result bit per operand bit pair, one step a cycle
  // --------------------------------------------------------------------------
  logic [RT_VAL_W-1:0] rt_val;
  logic [REM_W-1:0]    rt_rem;
  logic [RT_W-1:0]     rt_root;
  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic                take;
  logic [RT_W-1:0]     d1;
  logic                start_root;

  assign rem_sh = {rt_rem, rt_val[RT_VAL_W-1 -: 2]};
  assign trial  = (REM_W+2)'({rt_root, 2'b01});
  assign take   = (rem_sh >= trial);
  assign start_root = (state == ST_SCAN) && issue_done && pipe_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_cnt <= '0;
    end else if (start_root) begin
      rt_cnt <= '0;
    end else if (state == ST_ROOT1 || state == ST_ROOT2) begin
      if (root_last) rt_cnt <= '0;
      else           rt_cnt <= rt_cnt + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start_root || (state == ST_ROOT1 && root_last)) begin
      rt_val  <= RT_VAL_W'(start_root ? best1 : best2);
      rt_rem  <= '0;
      rt_root <= '0;
      if (!start_root) d1 <= take ? {rt_root[RT_W-2:0], 1'b1} : {rt_root[RT_W-2:0], 1'b0};
    end else if (state == ST_ROOT1 || state == ST_ROOT2) begin
      rt_val <= rt_val << 2;
      if (take) begin
        rt_rem  <= REM_W'(rem_sh - trial);
        rt_root <= {rt_root[RT_W-2:0], 1'b1};
      end else begin
        rt_rem  <= rem_sh[REM_W-1:0];
        rt_root <= {rt_root[RT_W-2:0], 1'b0};
      end
    end
  end

  // --------------------------------------------------------------------------
  // result register; rt_root holds F2 in hold state
  // --------------------------------------------------------------------------
  logic            few;
  logic [RT_W-1:0] near_full;
  logic [RT_W-1:0] gap_full;
  logic [31:0]     thr_scaled;

  assign few = 32'(scan_len) < 32'd2;

  always_comb begin
    if (!have1 || 32'(d1) >= 32'(NEAR_CLAMP)) near_full = RT_W'(NEAR_CLAMP);
    else                                      near_full = d1;
    if (few) gap_full = '0;
    else     gap_full = rt_root - d1;
    thr_scaled = 32'(edge_threshold) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && out_free) begin
      nearest_distance <= near_full[NEAR_W-1:0];
      gap_distance     <= GAP_W'(gap_full);
      on_edge          <= 32'(gap_full) < thr_scaled;
      too_few_seeds    <= few;
    end
  end

endmodule

// File: tb/nearest_two_seed_distance_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_two_seed_distance_tb
// Self-checking bench for the F1 / F2 seed distance search. A short table of
// directed items (empty table, single seed, duplicates, coordinate extremes)
// is followed by random phases with different register settings and
// handshake pressure. Every query result is compared with a local model or a typed answer.
// ----------------------------------------------------------------------------
module nearest_two_seed_distance_tb;
  import ntsd_pkg::*;

  localparam int SEED_SLOTS     = DEF_MAX_SEEDS;
  localparam int SETTLE_CYCLES  = SEED_SLOTS + 60;  // longest query plus margin
  localparam int HOLD_CYCLES    = 600;              // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PC_RANDOM      = -1;
  localparam int DIR_ROWS       = 23;
  localparam int PHASES         = 9;
  localparam int MAX_PRINTS     = 30;

  // one query answer as seen on the result port
  typedef struct packed {
    logic [NEAR_W-1:0] nearest;
    logic [GAP_W-1:0]  gap;
    logic              edge_flag;
    logic              few_flag;
  } dist_result_t;

  typedef enum {ROW_ITEM, ROW_REGS} row_kind_t;

  // directed row: for ROW_REGS, idx carries point_count and px the threshold
  typedef struct {
    row_kind_t kind;
    logic      opv;
    int        idx;
    int        px;
    int        py;
    bit        typed;
    int        t_near;
    int        t_gap;
    bit        t_edge;
    bit        t_few;
  } stim_row_t;

  typedef struct {
    int pc;
    int thr;
    int snd_idle;
    int rcv_stall;
    int items;
    bit hold;
  } phase_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       op;
  logic [INDEX_W-1:0]         seed_index;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic                       out_valid;
  logic                       out_stall;
  logic [NEAR_W-1:0]          nearest_distance;
  logic [GAP_W-1:0]           gap_distance;
  logic                       on_edge;
  logic                       too_few_seeds;

  nearest_two_seed_distance #(.MAX_SEEDS(SEED_SLOTS)) uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .seed_index       (seed_index),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .nearest_distance (nearest_distance),
    .gap_distance     (gap_distance),
    .on_edge          (on_edge),
    .too_few_seeds    (too_few_seeds)
  );

  // model state: seed tables, which entries hold a value, and the registers
  logic signed [COORD_W-1:0] seed_xs [SEED_SLOTS];
  logic signed [COORD_W-1:0] seed_ys [SEED_SLOTS];
  bit                        seed_set [SEED_SLOTS];
  int                        point_count_m;
  int                        edge_thr_m;

  dist_result_t pending_dists [$];   // answers still owed by the block
  bit           use_typed;           // next query takes typed_result as is
  dist_result_t typed_result;

  int  errors;
  int  writes_n;
  int  queries_n;
  int  results_n;
  int  settings_n;
  int  idle_run;
  int  sender_pct;
  int  stall_pct;
  bit  hold_req;

  // Directed items. Typed answers only where they are obvious: empty table,
  // query right on a seed, a corner seed against the origin, one seed nearby.
  stim_row_t dir_tab [DIR_ROWS] = '{
    // reset state: no seeds, clamp and forced gap, threshold 2 gives edge
    '{ROW_ITEM, OP_QUERY, 0, 0, 0, 1'b1, NEAR_CLAMP, 0, 1'b1, 1'b1},
    '{ROW_ITEM, OP_QUERY, 255, -32768, 32767, 1'b1, NEAR_CLAMP, 0, 1'b1, 1'b1},
    '{ROW_ITEM, OP_WRITE, 0, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0},
    '{ROW_ITEM, OP_WRITE, 1, -32768, -32768, 1'b0, 0, 0, 1'b0, 1'b0},
    '{ROW_ITEM, OP_WRITE, 255, 32767, 32767, 1'b0, 0, 0, 1'b0, 1'b0},
    '{ROW_ITEM, OP_WRITE, 2, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0},
    // one seed: gap forced to zero
    '{ROW_REGS, OP_WRITE, 1, 2, 0, 1'b0, 0, 0, 1'b0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 0, 0, 0, 1'b1, 0, 0, 1'b1, 1'b1},
    '{ROW_ITEM, OP_QUERY, 0, 32767, -32768, 1'b0, 0, 0, 1'b0, 1'b0},
    // two seeds, threshold zero never flags an edge
    '{ROW_REGS, OP_WRITE, 2, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 0, -32768, -32768, 1'b1, 0, 46340, 1'b0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 0, 32767, 32767, 1'b0, 0, 0, 1'b0, 1'b0},
    // duplicate seeds 0 and 2
    '{ROW_REGS, OP_WRITE, 3, 255, 0, 1'b0, 0, 0, 1'b0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 0, 16, 16, 1'b0, 0, 0, 1'b0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 0, -32768, -32768, 1'b0, 0, 0, 1'b0, 1'b0},
    '{ROW_ITEM, OP_WRITE, 3, 100, -100, 1'b0, 0, 0, 1'b0, 1'b0},
    // query halfway between seeds: equal distances
    '{ROW_REGS, OP_WRITE, 4, 1, 0, 1'b0, 0, 0, 1'b0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 0, 50, -50, 1'b0, 0, 0, 1'b0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 0, 100, -100, 1'b0, 0, 0, 1'b0, 1'b0},
    '{ROW_ITEM, OP_WRITE, 255, -1, 0, 1'b0, 0, 0, 1'b0, 1'b0},
    // forced gap with threshold zero: no edge
    '{ROW_REGS, OP_WRITE, 1, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0},
    '{ROW_ITEM, OP_QUERY, 0, 5, 5, 1'b1, 7, 0, 1'b0, 1'b1},
    '{ROW_ITEM, OP_QUERY, 0, -32768, 32767, 1'b0, 0, 0, 1'b0, 1'b0}
  };

  // random phases; the 256 and 511 settings need the whole table written,
  // so their first items turn into fill writes
  phase_t phases [PHASES] = '{
    '{4,         2,   0,  0,  150, 1'b0},
    '{8,         0,   64, 0,  150, 1'b0},
    '{1,         255, 0,  64, 100, 1'b0},
    '{16,        7,   38, 38, 150, 1'b0},
    '{0,         128, 0,  0,  60,  1'b0},
    '{256,       255, 0,  0,  300, 1'b0},
    '{511,       1,   38, 38, 40,  1'b0},
    '{5,         2,   0,  0,  150, 1'b1},
    '{PC_RANDOM, 3,   64, 0,  150, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // floor of the square root, one result bit per pass
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = v;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // F1 / F2 search over the active seeds for one query position
  function automatic dist_result_t predict_distances(logic signed [COORD_W-1:0] qx,
                                                     logic signed [COORD_W-1:0] qy);
    int              n;
    bit              have1;
    bit              have2;
    longint          dx;
    longint          dy;
    longint          sq;
    longint          best1;
    longint          best2;
    longint unsigned d1;
    longint unsigned gap;
    longint unsigned nearest;
    dist_result_t    r;
    n     = (point_count_m > SEED_SLOTS) ? SEED_SLOTS : point_count_m;
    have1 = 1'b0;
    have2 = 1'b0;
    best1 = 0;
    best2 = 0;
    for (int i = 0; i < n; i++) begin
      dx = longint'(qx) - longint'(seed_xs[i]);
      dy = longint'(qy) - longint'(seed_ys[i]);
      sq = dx * dx + dy * dy;
      if (!have1 || sq < best1) begin
        // a tie goes to second place, so duplicates give a zero gap
        if (have1) begin
          best2 = best1;
          have2 = 1'b1;
        end
        best1 = sq;
        have1 = 1'b1;
      end else if (!have2 || sq < best2) begin
        best2 = sq;
        have2 = 1'b1;
      end
    end
    nearest = NEAR_CLAMP;
    gap     = 0;
    if (have1) begin
      d1      = int_sqrt(best1);
      nearest = (d1 < NEAR_CLAMP) ? d1 : NEAR_CLAMP;
      if (have2 && n >= 2) gap = int_sqrt(best2) - d1;
    end
    r.nearest   = nearest[NEAR_W-1:0];
    r.gap       = gap[GAP_W-1:0];
    r.edge_flag = (gap < (longint'(edge_thr_m) << FRAC_BITS));
    r.few_flag  = (n < 2);
    return r;
  endfunction

  task automatic note_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch on result %0d: %s = %0d, expected %0d", results_n, what, got, want);
  endtask

  // Monitor: registers, results and items, all sampled at the rising edge.
  // Results are checked before a new query is queued; no result leaves in the cycle its query is taken.
  always @(posedge clk) begin : monitor
    dist_result_t want;
    bit           moved;
    if (rst) begin
      idle_run = 0;
    end else begin
      moved = 1'b0;
      if (cfg_write) begin
        moved = 1'b1;
        case (cfg_index)
          REG_POINT_COUNT:    point_count_m = int'(cfg_data);
          REG_EDGE_THRESHOLD: edge_thr_m    = int'(cfg_data[THR_W-1:0]);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        results_n++;
        if (pending_dists.size() == 0) begin
          note_mismatch("unexpected result, nearest_distance", nearest_distance, 0);
        end else begin
          want = pending_dists.pop_front();
          if (nearest_distance !== want.nearest)
            note_mismatch("nearest_distance", nearest_distance, want.nearest);
          if (gap_distance !== want.gap)
            note_mismatch("gap_distance", gap_distance, want.gap);
          if (on_edge !== want.edge_flag)
            note_mismatch("on_edge", on_edge, want.edge_flag);
          if (too_few_seeds !== want.few_flag)
            note_mismatch("too_few_seeds", too_few_seeds, want.few_flag);
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        if (op == OP_WRITE) begin
          seed_xs[seed_index]  = pos_x;
          seed_ys[seed_index]  = pos_y;
          seed_set[seed_index] = 1'b1;
          writes_n++;
        end else begin
          want = use_typed ? typed_result : predict_distances(pos_x, pos_y);
          pending_dists.push_back(want);
          queries_n++;
        end
      end
      // watchdog: nothing moved on any port for too long
      idle_run = moved ? 0 : idle_run + 1;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stall per cycle, or a long hold-off when asked for.
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offer one item from a falling edge; return at the falling edge after it
  // is taken, with valid still high so the next item can follow directly.
  task automatic send_item(logic o, logic [INDEX_W-1:0] idx,
                           logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    while (sender_pct != 0 && $urandom_range(0, 99) < sender_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= o;
    seed_index <= idx;
    pos_x      <= x;
    pos_y      <= y;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // drop valid, wait for every owed result, then let the block go quiet
  task automatic settle(int extra);
    in_valid <= 1'b0;
    while (pending_dists.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_regs(int pc, int thr);
    cfg_write <= 1'b1;
    cfg_index <= REG_POINT_COUNT;
    cfg_data  <= pc[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_EDGE_THRESHOLD;
    cfg_data  <= CFG_W'(thr[THR_W-1:0]);
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_n++;
  endtask

  function automatic logic signed [COORD_W-1:0] cluster_coord();
    int v;
    v = int'($urandom_range(0, 8191)) - 4096;   // within 256 pixels of the origin
    return v[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] jitter_coord(logic signed [COORD_W-1:0] base,
                                                             int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    return v[COORD_W-1:0];
  endfunction

  // One random item. A query that would scan a never-written entry becomes
  // a write to the lowest such entry, so the table fills before any scan.
  task automatic send_random_item();
    int                        n;
    int                        hole;
    int                        pick;
    int                        mode;
    int                        lim;
    logic                      o;
    logic [INDEX_W-1:0]        idx;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    n    = (point_count_m > SEED_SLOTS) ? SEED_SLOTS : point_count_m;
    hole = -1;
    for (int i = 0; i < n; i++) begin
      if (!seed_set[i]) begin
        hole = i;
        break;
      end
    end
    pick = (n > 0) ? int'($urandom_range(0, n - 1)) : 0;
    bx   = seed_set[pick] ? seed_xs[pick] : '0;
    by   = seed_set[pick] ? seed_ys[pick] : '0;
    mode = $urandom_range(0, 99);
    o    = $urandom_range(0, 1) ? OP_QUERY : OP_WRITE;
    if (o == OP_QUERY && hole < 0) begin
      idx = INDEX_W'($urandom_range(0, 255));   // ignored by the block
      if (mode < 50) begin
        x = jitter_coord(bx, 64);
        y = jitter_coord(by, 64);
      end else if (mode < 80) begin
        x = cluster_coord();
        y = cluster_coord();
      end else begin
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
      end
    end else begin
      o   = OP_WRITE;
      lim = (n == 0) ? 3 : ((n < SEED_SLOTS - 1) ? n + 1 : SEED_SLOTS - 1);
      if (hole >= 0) idx = INDEX_W'(hole);
      else if ($urandom_range(0, 3) == 0) idx = INDEX_W'($urandom_range(0, SEED_SLOTS - 1));
      else idx = INDEX_W'($urandom_range(0, lim));
      if (mode < 25) begin
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
      end else if (mode < 75) begin
        x = cluster_coord();
        y = cluster_coord();
      end else begin
        // duplicate or close neighbor of a live seed
        x = $urandom_range(0, 1) ? bx : jitter_coord(bx, 8);
        y = $urandom_range(0, 1) ? by : jitter_coord(by, 8);
      end
    end
    send_item(o, idx, x, y);
  endtask

  initial begin : stimulus
    int pc;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    op            = OP_WRITE;
    seed_index    = '0;
    pos_x         = '0;
    pos_y         = '0;
    point_count_m = 0;
    edge_thr_m    = 2;
    use_typed     = 1'b0;
    typed_result  = '0;
    errors        = 0;
    writes_n      = 0;
    queries_n     = 0;
    results_n     = 0;
    settings_n    = 0;
    idle_run      = 0;
    sender_pct    = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, no idling
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].kind == ROW_REGS) begin
        settle(SETTLE_CYCLES);
        write_regs(dir_tab[r].idx, dir_tab[r].px);
      end else begin
        use_typed              = dir_tab[r].typed;
        typed_result.nearest   = NEAR_W'(dir_tab[r].t_near);
        typed_result.gap       = GAP_W'(dir_tab[r].t_gap);
        typed_result.edge_flag = dir_tab[r].t_edge;
        typed_result.few_flag  = dir_tab[r].t_few;
        send_item(dir_tab[r].opv, INDEX_W'(dir_tab[r].idx),
                  COORD_W'(dir_tab[r].px), COORD_W'(dir_tab[r].py));
        use_typed = 1'b0;
      end
    end

    // random phases, registers rewritten only with the block quiet
    for (int p = 0; p < PHASES; p++) begin
      settle(SETTLE_CYCLES);
      pc = (phases[p].pc == PC_RANDOM) ? int'($urandom_range(2, 40)) : phases[p].pc;
      write_regs(pc, phases[p].thr);
      sender_pct = phases[p].snd_idle;
      stall_pct  = phases[p].rcv_stall;
      if (phases[p].hold) hold_req = 1'b1;   // block fills and stalls its input
      for (int k = 0; k < phases[p].items; k++) begin
        // halfway through the pressure phase the sender stops until all is back
        if (phases[p].hold && k == phases[p].items / 2) settle(0);
        send_random_item();
      end
    end

    settle(SETTLE_CYCLES);
    $display("covered %0d seed writes and %0d queries over %0d register settings,",
             writes_n, queries_n, settings_n);
    $display("with %0d results compared under idle, stall and hold-off pressure", results_n);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
